// ===== design/cud_pkg.sv =====
`default_nettype none

package cud_pkg;

    // default sizing
    localparam int QueueDepth  = 128;
    localparam int CreditWidth = 16;

    // protocol and register reset values
    localparam logic [7:0]  UdpProtocol          = 8'd17;
    localparam logic [15:0] ServicePortReset     = 16'd8080;
    localparam logic [15:0] ServerOnePortReset   = 16'd8081;
    localparam logic [15:0] ServerTwoPortReset   = 16'd8082;
    localparam logic [15:0] ServerThreePortReset = 16'd8083;
    localparam logic [15:0] InitialCreditReset   = 16'd5;

    localparam int CfgIndexWidth = 3;
    localparam int NumServers    = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SERVICE_PORT      = 3'd0,
        CFG_SERVER_ONE_PORT   = 3'd1,
        CFG_SERVER_TWO_PORT   = 3'd2,
        CFG_SERVER_THREE_PORT = 3'd3,
        CFG_INITIAL_CREDIT    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic        headers_complete;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [31:0] payload_word;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        logic [15:0] out_source_port;
        logic [15:0] out_dest_port;
        logic [31:0] out_payload_word;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/credit_udp_dispatcher_unit.sv =====
`default_nettype none

// credit based udp dispatcher: each packet header item gets exactly one result item, in
// order. packets that are incomplete, not udp or not sent to the service port pass
// unchanged. the first qualifying packet loads all three server credit counters with
// initial_credit (cut to CREDIT_WIDTH bits). a client packet is steered to the first server
// with credit (its destination port rewritten, one credit taken); with no credit left its
// payload word is queued in the backlog memory and the packet is dropped, a full backlog
// overwriting its oldest word. a packet from a server port takes the oldest backlog word,
// swaps ports and passes back to that server from the service port; with an empty backlog
// it returns one credit (saturating) and is dropped. throughput is one item per clock unless
// stalled: the credit counters and backlog pointers are updated at the edge that accepts an
// item, and the backlog memory is read or written once at that edge, where the result is
// registered, its payload word taken from the memory's registered read port on a pop.
// configuration writes are always accepted and must only be made while the block is idle.

module credit_udp_dispatcher_unit #(
    parameter int QUEUE_DEPTH  = cud_pkg::QueueDepth,
    parameter int CREDIT_WIDTH = cud_pkg::CreditWidth
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // packet header items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire cud_pkg::t_in_item                   i_in_item,
    // result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output cud_pkg::t_out_item                       o_out_item,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [cud_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  wire logic [15:0]                         i_cfg_data
);

    localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
    localparam int NServ      = cud_pkg::NumServers;

    // configuration registers
    logic [15:0] r_service_port;
    logic [15:0] r_server_port [NServ];
    logic [15:0] r_initial_credit;

    // credit state
    logic [CREDIT_WIDTH-1:0] r_credit [NServ];
    logic [CREDIT_WIDTH-1:0] n_credit [NServ];
    logic                    r_loaded;

    // backlog pointers
    logic [PtrWidth-1:0]   r_head, n_head;
    logic [PtrWidth-1:0]   r_tail, n_tail;
    logic [CountWidth-1:0] r_count, n_count;

    // result stage
    logic               r_s1_valid;
    logic               r_s1_pop;
    cud_pkg::t_out_item r_s1;
    cud_pkg::t_out_item n_s1;

    // decode
    logic                    w_accept;
    logic                    w_qualify;
    logic [CREDIT_WIDTH-1:0] w_init_credit;
    logic [CREDIT_WIDTH-1:0] w_eff [NServ];
    logic [NServ-1:0]        w_match;
    logic [NServ-1:0]        w_has_credit;
    logic                    w_pop;
    logic                    w_push;
    logic [31:0]             w_rdata;

    assign o_cfg_ready   = 1'b1;
    assign w_init_credit = CREDIT_WIDTH'(r_initial_credit);
    assign o_in_ready    = !r_s1_valid || i_out_ready;
    assign w_accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port   <= cud_pkg::ServicePortReset;
            r_server_port[0] <= cud_pkg::ServerOnePortReset;
            r_server_port[1] <= cud_pkg::ServerTwoPortReset;
            r_server_port[2] <= cud_pkg::ServerThreePortReset;
            r_initial_credit <= cud_pkg::InitialCreditReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cud_pkg::CFG_SERVICE_PORT:      r_service_port   <= i_cfg_data;
                cud_pkg::CFG_SERVER_ONE_PORT:   r_server_port[0] <= i_cfg_data;
                cud_pkg::CFG_SERVER_TWO_PORT:   r_server_port[1] <= i_cfg_data;
                cud_pkg::CFG_SERVER_THREE_PORT: r_server_port[2] <= i_cfg_data;
                cud_pkg::CFG_INITIAL_CREDIT:    r_initial_credit <= i_cfg_data;
                default: begin
                    // unknown index, write ignored
                end
            endcase
        end
    end

    // packet classification, credits as seen by this item
    always_comb begin
        w_qualify = i_in_item.headers_complete
                 && (i_in_item.ip_protocol == cud_pkg::UdpProtocol)
                 && (i_in_item.dst_port == r_service_port);
        for (int i = 0; i < NServ; i++) begin
            w_eff[i]        = r_loaded ? r_credit[i] : w_init_credit;
            w_has_credit[i] = (w_eff[i] != '0);
        end
        // lowest numbered matching server wins
        w_match[0] = (i_in_item.source_port == r_server_port[0]);
        w_match[1] = !w_match[0] && (i_in_item.source_port == r_server_port[1]);
        w_match[2] = !w_match[0] && !w_match[1]
                  && (i_in_item.source_port == r_server_port[2]);
        w_pop  = w_accept && w_qualify && (w_match != '0) && (r_count != '0);
        w_push = w_accept && w_qualify && (w_match == '0) && (w_has_credit == '0);
    end

    // next state and result
    always_comb begin
        logic dispatched;
        dispatched = 1'b0;
        n_head = r_head;
        n_tail = r_tail;
        n_count = r_count;
        n_s1.verdict          = 1'b0;
        n_s1.out_source_port  = i_in_item.source_port;
        n_s1.out_dest_port    = i_in_item.dst_port;
        n_s1.out_payload_word = i_in_item.payload_word;
        for (int i = 0; i < NServ; i++) begin
            n_credit[i] = r_credit[i];
        end

        if (w_accept && w_qualify) begin
            for (int i = 0; i < NServ; i++) begin
                n_credit[i] = w_eff[i];
            end
            if (w_match != '0) begin
                if (r_count != '0) begin
                    // back to the server from the service port
                    n_s1.out_source_port = r_service_port;
                    n_s1.out_dest_port   = i_in_item.source_port;
                    n_head  = (r_head == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_head + PtrWidth'(1);
                    n_count = r_count - CountWidth'(1);
                end else begin
                    // credit return, saturating
                    for (int i = 0; i < NServ; i++) begin
                        if (w_match[i] && (w_eff[i] != '1)) begin
                            n_credit[i] = w_eff[i] + CREDIT_WIDTH'(1);
                        end
                    end
                    n_s1.verdict = 1'b1;
                end
            end else begin
                for (int i = 0; i < NServ; i++) begin
                    if (!dispatched && w_has_credit[i]) begin
                        dispatched          = 1'b1;
                        n_credit[i]         = w_eff[i] - CREDIT_WIDTH'(1);
                        n_s1.out_dest_port  = r_server_port[i];
                    end
                end
                if (!dispatched) begin
                    n_s1.verdict = 1'b1;
                    n_tail = (r_tail == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_tail + PtrWidth'(1);
                    if (r_count == CountWidth'(QUEUE_DEPTH)) begin
                        // full: oldest word is overwritten
                        n_head = (r_head == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_head + PtrWidth'(1);
                    end else begin
                        n_count = r_count + CountWidth'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_pop   <= 1'b0;
            for (int i = 0; i < NServ; i++) begin
                r_credit[i] <= '0;
            end
        end else begin
            if (w_accept && w_qualify) begin
                r_loaded <= 1'b1;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            for (int i = 0; i < NServ; i++) begin
                r_credit[i] <= n_credit[i];
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_pop   <= w_pop;
            end else if (i_out_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // backlog store: at most one write (push) or one read (pop) per accepted item
    cud_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_backlog (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_tail),
        .i_wdata (i_in_item.payload_word),
        .i_re    (w_pop),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_out_valid = r_s1_valid;
        o_out_item  = r_s1;
        if (r_s1_pop) begin
            o_out_item.out_payload_word = w_rdata;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountWidth'(QUEUE_DEPTH))
        else $error("backlog count above depth");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CountWidth'(QUEUE_DEPTH)) |-> (r_head == r_tail))
        else $error("backlog pointers disagree with count");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_s1_valid && r_s1_pop && !r_s1.verdict))
        else $error("pop result not presented as a pass");

    a_loaded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded |=> r_loaded)
        else $error("credits loaded flag cleared");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_out_ready) |=> ($stable(o_out_item) && o_out_valid))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== design/cud_ram.sv =====
`default_nettype none

module cud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
